>>> src/gamepad_hid_report_responder_macros.svh
`ifndef GAMEPAD_HID_REPORT_RESPONDER_MACROS_SVH
`define GAMEPAD_HID_REPORT_RESPONDER_MACROS_SVH

// condition holds in the same cycle
`define GHRR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define GHRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ghrr_pkg.sv
package ghrr_pkg;

   localparam int REPORT_BYTES = 64;
   localparam int BYTE_IDX_W   = $clog2(REPORT_BYTES);
   localparam int ROM_SPAN     = REPORT_BYTES - 20;
   localparam int ROM_A_LEN    = 92;
   localparam int ROM_B_LEN    = 38;

   localparam logic [1:0] REQ_HOST  = 2'd0;
   localparam logic [1:0] REQ_FRAME = 2'd1;
   localparam logic [1:0] REQ_POLL  = 2'd2;

   localparam logic CSR_TRANSPORT = 1'b0;
   localparam logic CSR_MAC       = 1'b1;

   localparam logic [47:0] MAC_RESET = 48'h7CBB8A204001;

   localparam logic [7:0] RID_FEATURE = 8'h01;
   localparam logic [7:0] RID_RUMBLE  = 8'h10;
   localparam logic [7:0] RID_CONFIG  = 8'h80;

   localparam logic [7:0] SUB_DEV_QUERY = 8'h01;
   localparam logic [7:0] SUB_LINK_SYNC = 8'h02;
   localparam logic [7:0] SUB_BAUD      = 8'h03;
   localparam logic [7:0] SUB_NO_TMO    = 8'h04;
   localparam logic [7:0] SUB_TMO       = 8'h05;

   localparam logic [7:0] CMD_STATE      = 8'h01;
   localparam logic [7:0] CMD_DEVINFO    = 8'h02;
   localparam logic [7:0] CMD_MODE       = 8'h03;
   localparam logic [7:0] CMD_TRIGGER    = 8'h04;
   localparam logic [7:0] CMD_FLASH_READ = 8'h10;
   localparam logic [7:0] CMD_LIGHTS     = 8'h30;
   localparam logic [7:0] CMD_GET_LITE   = 8'h31;
   localparam logic [7:0] CMD_VOLTAGE    = 8'h50;

   localparam logic [7:0] MODE_STD  = 8'h30;
   localparam logic [7:0] MODE_SIMP = 8'h3F;

   localparam logic [7:0] ROM_A [ROM_A_LEN] = '{
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'h03,8'hA0,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'h02,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hE3,8'hFF,8'h39,8'hFF,8'hED,8'h01,8'h00,8'h40,
      8'h00,8'h40,8'h00,8'h40,8'h09,8'h00,8'hEA,8'hFF,
      8'hA1,8'hFF,8'h3B,8'h34,8'h3B,8'h34,8'h3B,8'h34,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hA4,8'h46,8'h6A,8'h00,8'h08,8'h80,8'hA4,8'h46,8'h6A,
      8'h00,8'h08,8'h80,8'hA4,8'h46,8'h6A,8'hA4,8'h46,8'h6A,
      8'hFF,8'h1B,8'h1B,8'h1D,8'hFF,8'hFF,8'hFF,8'hEC,8'h00,8'h8C,
      8'hEC,8'h00,8'h8C
   };

   localparam logic [7:0] ROM_B [ROM_B_LEN] = '{
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hB2,8'hA1,8'hA4,8'h46,8'h6A,8'h00,8'h08,8'h80,8'hA4,8'h46,8'h6A,
      8'hB2,8'hA1,8'h00,8'h08,8'h80,8'hA4,8'h46,8'h6A,8'hA4,8'h46,8'h6A
   };

   typedef enum logic [1:0] {SRC_REPLY, SRC_IDENT, SRC_STD} src_type;
   typedef enum logic [1:0] {REGION_NONE, REGION_A, REGION_B} region_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  host_rid;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [13:0] buttons;
      logic [3:0]  dpad;
      logic [15:0] left_x;
      logic [15:0] left_y;
      logic [15:0] right_x;
      logic [15:0] right_y;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] report_byte;
      logic       report_last;
      logic       ready_now;
   } rsp_payload_type;

   typedef struct packed {
      logic rx_write;
      logic decode;
      logic pack;
      logic poll_start;
      logic emit_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic byte_last;
   } dp_sts_type;

endpackage

>>> src/ghrr_ctrl.sv
`include "gamepad_hid_report_responder_macros.svh"

module ghrr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_kind,
   input  logic                      req_last,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ghrr_pkg::ctrl_cmd_type    cmd,
   input  ghrr_pkg::dp_sts_type      sts
);
   import ghrr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  REQ_HOST: begin
                     cmd.rx_write = 1'b1;
                     if (req_last) begin
                        state_in = ST_DECODE;
                     end
                  end
                  REQ_FRAME: begin
                     cmd.pack = 1'b1;
                  end
                  REQ_POLL: begin
                     cmd.poll_start = 1'b1;
                     state_in       = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.emit_step = 1'b1;
               if (sts.byte_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   `GHRR_ASSERT_NOW(a_no_intake_in_emit, rsp_valid, req_stall, "input taken during emission")
   `GHRR_ASSERT_NEXT(a_decode_one_cycle, state_ff == ST_DECODE, state_ff == ST_IDLE, "decode stuck")
   `GHRR_ASSERT_NEXT(a_end_after_last, rsp_valid && !rsp_stall && sts.byte_last, !rsp_valid,
                     "extra report byte")

endmodule

>>> src/ghrr_datapath.sv
module ghrr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ghrr_pkg::ctrl_cmd_type     cmd,
   output ghrr_pkg::dp_sts_type       sts,
   input  ghrr_pkg::req_payload_type  req_data,
   output ghrr_pkg::rsp_payload_type  rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [47:0]                csr_wdata
);
   import ghrr_pkg::*;

   logic                          transport_ff;
   logic [47:0]                   mac_ff;
   logic [7:0]                    rx_head_ff [16];
   logic [6:0]                    rx_count_ff;
   logic [7:0]                    rid_ff;
   logic                          pending_ff;
   logic                          ready_ff;
   logic [7:0]                    ts_ff;
   logic [7:0]                    lights_ff;
   logic [9:0][7:0]               status_ff;
   logic                          rep_cfg_ff;
   logic [7:0]                    rep_code_ff;
   logic [7:0]                    rep_ts_ff;
   logic [9:0][7:0]               rep_status_ff;
   logic [5:0][7:0]               rep_arg_ff;
   logic [47:0]                   rep_mac_ff;
   logic [7:0]                    rep_size_ff;
   region_type                    rep_region_ff;
   logic [7:0]                    rep_off_ff;
   src_type                       src_ff;
   logic [BYTE_IDX_W-1:0]         k_ff;

   logic                          ready_now;
   logic                          realign;
   logic [7:0]                    p [16];
   logic [7:0]                    len;
   logic                          do_cfg;
   logic                          do_feat;
   logic [31:0]                   addr;
   region_type                    region;
   logic [7:0]                    size_clamp;
   logic [9:0][7:0]               packed_st;
   logic [7:0]                    kx;
   logic [3:0]                    sidx;
   logic [7:0]                    j;
   logic [8:0]                    ridx;
   logic [7:0]                    rom_byte;
   logic [7:0]                    out_byte;

   function automatic logic known_id(input logic [7:0] id);
      return (id == RID_FEATURE) || (id == RID_RUMBLE) || (id == RID_CONFIG);
   endfunction

   function automatic logic [7:0] ident_byte(input logic [7:0] k, input logic [47:0] mac);
      logic [7:0] b;
      b = 8'h00;
      case (k)
         8'd0: b = 8'h81;
         8'd1: b = 8'h01;
         8'd3: b = 8'h03;
         8'd4: b = mac[7:0];
         8'd5: b = mac[15:8];
         8'd6: b = mac[23:16];
         8'd7: b = mac[31:24];
         8'd8: b = mac[39:32];
         8'd9: b = mac[47:40];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   assign ready_now = ready_ff | transport_ff;

   // host report realignment
   always_comb begin
      realign = !known_id(rx_head_ff[0]) && known_id(rid_ff);
      p[0] = realign ? rid_ff : rx_head_ff[0];
      for (int i = 1; i < 16; i++) begin
         p[i] = realign ? rx_head_ff[i-1] : rx_head_ff[i];
      end
      len     = {1'b0, rx_count_ff} + {7'd0, realign};
      do_cfg  = (p[0] == RID_CONFIG) && (len > 8'd1);
      do_feat = (p[0] == RID_FEATURE) && (len >= 8'd11);
      addr    = {p[14], p[13], p[12], p[11]};
      if (addr[31:8] == 24'h000060) begin
         region = REGION_A;
      end else if (addr[31:8] == 24'h000080) begin
         region = REGION_B;
      end else begin
         region = REGION_NONE;
      end
      size_clamp = (p[15] > 8'(ROM_SPAN)) ? 8'(ROM_SPAN) : p[15];
   end

   // controller frame to 10-byte input status
   always_comb begin
      logic [11:0] lx, ly, rx, ry;
      lx = req_data.left_x[15:4];
      ly = ~req_data.left_y[15:4];
      rx = req_data.right_x[15:4];
      ry = ~req_data.right_y[15:4];
      packed_st[0] = 8'h90;
      packed_st[1] = {req_data.buttons[7], req_data.buttons[5], 2'b00,
                      req_data.buttons[1], req_data.buttons[0],
                      req_data.buttons[3], req_data.buttons[2]};
      packed_st[2] = {2'b10, req_data.buttons[13], req_data.buttons[12],
                      req_data.buttons[10], req_data.buttons[11],
                      req_data.buttons[9], req_data.buttons[8]};
      packed_st[3] = {req_data.buttons[6], req_data.buttons[4], 2'b00,
                      req_data.dpad[2], req_data.dpad[3],
                      req_data.dpad[0], req_data.dpad[1]};
      packed_st[4] = lx[7:0];
      packed_st[5] = {ly[3:0], lx[11:8]};
      packed_st[6] = ly[11:4];
      packed_st[7] = rx[7:0];
      packed_st[8] = {ry[3:0], rx[11:8]};
      packed_st[9] = ry[11:4];
   end

   // reply byte generator
   always_comb begin
      kx   = 8'(k_ff);
      sidx = 4'(kx - 8'd2);
      j    = kx - 8'd20;
      ridx = {1'b0, rep_off_ff} + {1'b0, j};
      rom_byte = 8'hFF;
      case (rep_region_ff)
         REGION_A: begin
            if (ridx < 9'(ROM_A_LEN)) begin
               rom_byte = ROM_A[ridx[6:0]];
            end
         end
         REGION_B: begin
            if (ridx < 9'(ROM_B_LEN)) begin
               rom_byte = ROM_B[ridx[5:0]];
            end
         end
         default: rom_byte = 8'hFF;
      endcase
      if (j >= rep_size_ff) begin
         rom_byte = 8'h00;
      end

      out_byte = 8'h00;
      case (src_ff)
         SRC_STD: begin
            if (kx == 8'd0) begin
               out_byte = 8'h30;
            end else if (kx == 8'd1) begin
               out_byte = ts_ff;
            end else if (kx < 8'd12) begin
               out_byte = status_ff[sidx];
            end else if (kx == 8'd12) begin
               out_byte = 8'h09;
            end
         end
         SRC_IDENT: out_byte = ident_byte(kx, mac_ff);
         default: begin
            if (rep_cfg_ff) begin
               if (rep_code_ff == SUB_DEV_QUERY) begin
                  out_byte = ident_byte(kx, rep_mac_ff);
               end else if (kx == 8'd0) begin
                  out_byte = (rep_code_ff == SUB_LINK_SYNC || rep_code_ff == SUB_BAUD)
                             ? 8'h81 : 8'h30;
               end else if (kx == 8'd1) begin
                  out_byte = rep_code_ff;
               end
            end else if (kx == 8'd0) begin
               out_byte = 8'h21;
            end else if (kx == 8'd1) begin
               out_byte = rep_ts_ff;
            end else if (kx < 8'd12) begin
               out_byte = rep_status_ff[sidx];
            end else begin
               case (rep_code_ff)
                  CMD_STATE: begin
                     case (kx)
                        8'd13:   out_byte = 8'h81;
                        8'd14:   out_byte = rep_code_ff;
                        8'd15:   out_byte = 8'h03;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_DEVINFO: begin
                     case (kx)
                        8'd13:   out_byte = 8'h82;
                        8'd14:   out_byte = 8'h02;
                        8'd15:   out_byte = 8'h04;
                        8'd16:   out_byte = 8'h91;
                        8'd17:   out_byte = 8'h03;
                        8'd18:   out_byte = 8'h02;
                        8'd19:   out_byte = rep_mac_ff[47:40];
                        8'd20:   out_byte = rep_mac_ff[39:32];
                        8'd21:   out_byte = rep_mac_ff[31:24];
                        8'd22:   out_byte = rep_mac_ff[23:16];
                        8'd23:   out_byte = rep_mac_ff[15:8];
                        8'd24:   out_byte = rep_mac_ff[7:0];
                        8'd25:   out_byte = 8'h01;
                        8'd26:   out_byte = 8'h02;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_MODE: begin
                     case (kx)
                        8'd13:   out_byte = 8'h80;
                        8'd14:   out_byte = 8'h03;
                        8'd15:   out_byte = rep_arg_ff[1];
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_TRIGGER: begin
                     case (kx)
                        8'd13:   out_byte = 8'h83;
                        8'd14:   out_byte = 8'h04;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_FLASH_READ: begin
                     case (kx)
                        8'd12:   out_byte = 8'h00;
                        8'd13:   out_byte = 8'h90;
                        8'd14:   out_byte = rep_arg_ff[0];
                        8'd15:   out_byte = rep_arg_ff[1];
                        8'd16:   out_byte = rep_arg_ff[2];
                        8'd17:   out_byte = rep_arg_ff[3];
                        8'd18:   out_byte = rep_arg_ff[4];
                        8'd19:   out_byte = rep_arg_ff[5];
                        default: out_byte = rom_byte;
                     endcase
                  end
                  CMD_LIGHTS: begin
                     case (kx)
                        8'd13:   out_byte = 8'h80;
                        8'd14:   out_byte = rep_code_ff;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_GET_LITE: begin
                     case (kx)
                        8'd13:   out_byte = 8'hB0;
                        8'd14:   out_byte = rep_code_ff;
                        8'd15:   out_byte = lights_ff;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  CMD_VOLTAGE: begin
                     case (kx)
                        8'd13:   out_byte = 8'hD0;
                        8'd14:   out_byte = 8'h50;
                        8'd15:   out_byte = 8'h83;
                        8'd16:   out_byte = 8'h06;
                        default: out_byte = 8'h00;
                     endcase
                  end
                  default: begin
                     case (kx)
                        8'd13:   out_byte = 8'h80;
                        8'd14:   out_byte = rep_code_ff;
                        8'd15:   out_byte = 8'h03;
                        default: out_byte = 8'h00;
                     endcase
                  end
               endcase
            end
         end
      endcase
   end

   assign sts.byte_last        = (k_ff == BYTE_IDX_W'(REPORT_BYTES - 1));
   assign rsp_data.report_byte = out_byte;
   assign rsp_data.report_last = sts.byte_last;
   assign rsp_data.ready_now   = ready_now;

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         transport_ff <= 1'b0;
         mac_ff       <= MAC_RESET;
         for (int i = 0; i < 16; i++) begin
            rx_head_ff[i] <= 8'h00;
         end
         rx_count_ff  <= '0;
         pending_ff   <= 1'b0;
         ready_ff     <= 1'b0;
         ts_ff        <= 8'h00;
         lights_ff    <= 8'h00;
         status_ff    <= {8'h7F, 8'hF7, 8'hFF, 8'h7F, 8'hF7, 8'hFF,
                          8'h00, 8'h80, 8'h00, 8'h90};
         k_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TRANSPORT: transport_ff <= csr_wdata[0];
               CSR_MAC:       mac_ff       <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.rx_write) begin
            if (rx_count_ff < 7'd16) begin
               rx_head_ff[rx_count_ff[3:0]] <= req_data.data_byte;
            end
            if (rx_count_ff != 7'd127) begin
               rx_count_ff <= rx_count_ff + 7'd1;
            end
         end
         if (cmd.pack) begin
            status_ff <= packed_st;
         end
         if (cmd.decode) begin
            if (do_cfg) begin
               pending_ff <= 1'b1;
               if (p[1] == SUB_NO_TMO || p[1] == SUB_TMO) begin
                  ready_ff <= 1'b1;
               end
            end else if (do_feat) begin
               pending_ff <= 1'b1;
               if (p[10] == CMD_MODE && (p[11] == MODE_STD || p[11] == MODE_SIMP)) begin
                  ready_ff <= 1'b1;
               end
               if (p[10] == CMD_LIGHTS) begin
                  lights_ff <= p[11];
               end
            end
            for (int i = 0; i < 16; i++) begin
               rx_head_ff[i] <= 8'h00;
            end
            rx_count_ff <= '0;
         end
         if (cmd.poll_start) begin
            pending_ff <= 1'b0;
            k_ff       <= '0;
         end
         if (cmd.emit_step) begin
            k_ff <= k_ff + BYTE_IDX_W'(1);
            if (sts.byte_last) begin
               ts_ff <= ts_ff + 8'd1;
            end
         end
      end
   end

   // reply descriptor and report source
   always_ff @(posedge clock) begin
      if (cmd.rx_write) begin
         rid_ff <= req_data.host_rid;
      end
      if (cmd.decode && do_cfg) begin
         rep_cfg_ff  <= 1'b1;
         rep_code_ff <= p[1];
         rep_mac_ff  <= mac_ff;
      end else if (cmd.decode && do_feat) begin
         rep_cfg_ff    <= 1'b0;
         rep_code_ff   <= p[10];
         rep_ts_ff     <= ts_ff;
         rep_status_ff <= status_ff;
         rep_arg_ff    <= {p[15], p[14], p[13], p[12], p[11], p[10]};
         rep_mac_ff    <= mac_ff;
         rep_size_ff   <= size_clamp;
         rep_region_ff <= region;
         rep_off_ff    <= addr[7:0];
      end
      if (cmd.poll_start) begin
         if (pending_ff) begin
            src_ff <= SRC_REPLY;
         end else if (!ready_now) begin
            src_ff <= SRC_IDENT;
         end else begin
            src_ff <= SRC_STD;
         end
      end
   end

endmodule

>>> src/gamepad_hid_report_responder.sv
// Game controller HID responder. Host output reports come in one byte per
// transaction and are decoded in the cycle after their last byte; controller
// frames update the registered input status when taken. A poll returns one
// 64-byte report, one byte per cycle while rsp_stall is low; no new request
// is taken until the last byte has gone. The report bytes are generated on
// the fly from a reply descriptor by a byte counter.
module gamepad_hid_report_responder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ghrr_pkg::req_payload_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ghrr_pkg::rsp_payload_type  rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [47:0]                csr_wdata
);
   import ghrr_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   ghrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_last  (req_data.last_byte),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ghrr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
